FILE: sv/aeds_pkg.sv
// ============================================================================
// aeds_pkg
// Shared types and constants of the arithmetic expansion delimiter scanner.
// ============================================================================
package aeds_pkg;

    localparam int DEFAULT_STACK_DEPTH = 32;
    localparam int QUEUE_DEPTH = 4;

    // Status codes of a result.
    localparam logic [2:0] ST_RUN        = 3'd0;
    localparam logic [2:0] ST_DONE       = 3'd1;
    localparam logic [2:0] ST_INCOMPLETE = 3'd2;
    localparam logic [2:0] ST_LONE       = 3'd3;
    localparam logic [2:0] ST_UNMATCHED  = 3'd4;
    localparam logic [2:0] ST_MISMATCH   = 3'd5;
    localparam logic [2:0] ST_OVERFLOW   = 3'd6;

    // Input commands.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Characters the scanner looks at.
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_BTICK   = 8'h60;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_BSL    = 2'd1,
        PEND_DOLLAR = 2'd2,
        PEND_CLOSE  = 2'd3
    } pend_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic [2:0] status;
        logic       split_fields;
        logic       last;
    } result_t;

    // What the scan logic needs to know about the bracket stack.
    typedef struct packed {
        logic empty;
        logic full;
        logic top_brace;
    } stack_view_t;

    // What the scan logic asks the bracket stack to do.
    typedef struct packed {
        logic clear;
        logic push;
        logic push_brace;
        logic pop;
    } stack_op_t;

endpackage

FILE: sv/aeds_step.sv
// ============================================================================
// aeds_step
// Combinational scan of one request: results, lookahead and stack update.
// ============================================================================
module aeds_step (
    input  logic                 cmd,
    input  logic [7:0]           byte_in,
    input  aeds_pkg::pend_t      pend,
    input  aeds_pkg::stack_view_t view,
    input  logic                 in_double_quote,
    output aeds_pkg::result_t    res0,
    output aeds_pkg::result_t    res1,
    output logic [1:0]           res_count,
    output aeds_pkg::pend_t      pend_next,
    output aeds_pkg::stack_op_t  op
);
    import aeds_pkg::*;

    // Scan of the byte as a fresh character.
    logic       scan_emit;
    logic [2:0] scan_st;
    pend_t      scan_pend;
    logic       scan_push;
    logic       scan_pop;

    // Prefix character, scanned character and status result.
    logic       a_v;
    logic [7:0] a_ch;
    logic       b_v;
    logic       s_v;
    logic [2:0] st;
    logic       split;
    logic       use_scan;
    result_t    ra;
    result_t    rb;
    result_t    rs;

    always_comb
    begin
        scan_emit = 1'b0;
        scan_st   = ST_RUN;
        scan_pend = PEND_NONE;
        scan_push = 1'b0;
        scan_pop  = 1'b0;
        if (byte_in == CH_RPAREN && view.empty)
        begin
            scan_pend = PEND_CLOSE;
        end
        else if (byte_in == CH_LPAREN || byte_in == CH_LBRACE)
        begin
            if (view.full)
            begin
                scan_st = ST_OVERFLOW;
            end
            else
            begin
                scan_push = 1'b1;
                scan_emit = 1'b1;
            end
        end
        else if (byte_in == CH_RPAREN || byte_in == CH_RBRACE)
        begin
            if (view.empty)
            begin
                scan_st = ST_UNMATCHED;
            end
            else
            begin
                scan_pop = 1'b1;
                if (view.top_brace != (byte_in == CH_RBRACE))
                begin
                    scan_st = ST_MISMATCH;
                end
                else
                begin
                    scan_emit = 1'b1;
                end
            end
        end
        else if (byte_in == CH_BSLASH)
        begin
            scan_pend = PEND_BSL;
        end
        else if (byte_in == CH_DOLLAR)
        begin
            scan_pend = PEND_DOLLAR;
        end
        else
        begin
            scan_emit = 1'b1;
        end
    end

    always_comb
    begin
        a_v      = 1'b0;
        a_ch     = CH_BSLASH;
        use_scan = 1'b0;
        st       = ST_RUN;
        split    = 1'b0;
        if (cmd == CMD_END)
        begin
            if (pend == PEND_BSL)
            begin
                a_v  = 1'b1;
                a_ch = CH_BSLASH;
            end
            else if (pend == PEND_DOLLAR)
            begin
                a_v  = 1'b1;
                a_ch = CH_DOLLAR;
            end
            st = ST_INCOMPLETE;
        end
        else
        begin
            case (pend)
                PEND_BSL:
                begin
                    if (byte_in == CH_DOLLAR || byte_in == CH_BTICK || byte_in == CH_BSLASH)
                    begin
                        a_v  = 1'b1;
                        a_ch = byte_in;
                    end
                    else if (byte_in != CH_NEWLINE)
                    begin
                        a_v      = 1'b1;
                        a_ch     = CH_BSLASH;
                        use_scan = 1'b1;
                    end
                end
                PEND_DOLLAR:
                begin
                    // A dollar followed by an opener pushes it exactly as a fresh opener.
                    a_v      = 1'b1;
                    a_ch     = CH_DOLLAR;
                    use_scan = 1'b1;
                end
                PEND_CLOSE:
                begin
                    if (byte_in == CH_RPAREN)
                    begin
                        st    = ST_DONE;
                        split = ~in_double_quote;
                    end
                    else
                    begin
                        st = ST_LONE;
                    end
                end
                default:
                begin
                    use_scan = 1'b1;
                end
            endcase
            if (use_scan)
            begin
                st = scan_st;
            end
        end
    end

    always_comb
    begin
        b_v = use_scan & scan_emit;
        s_v = (st != ST_RUN);

        ra = '{char_out: a_ch, char_valid: 1'b1, status: ST_RUN,
               split_fields: 1'b0, last: 1'b0};
        rb = '{char_out: byte_in, char_valid: 1'b1, status: ST_RUN,
               split_fields: 1'b0, last: 1'b0};
        rs = '{char_out: 8'd0, char_valid: 1'b0, status: st,
               split_fields: split, last: 1'b0};

        res_count = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, s_v});

        if (a_v)
        begin
            res0 = ra;
        end
        else if (b_v)
        begin
            res0 = rb;
        end
        else
        begin
            res0 = rs;
        end
        res1      = (a_v && b_v) ? rb : rs;
        res0.last = (res_count == 2'd1);
        res1.last = 1'b1;

        op.clear      = s_v;
        op.push       = use_scan & scan_push & ~s_v;
        op.push_brace = (byte_in == CH_LBRACE);
        op.pop        = use_scan & scan_pop & ~s_v;

        if (s_v)
        begin
            pend_next = PEND_NONE;
        end
        else if (use_scan)
        begin
            pend_next = scan_pend;
        end
        else
        begin
            pend_next = PEND_NONE;
        end
    end

endmodule

FILE: sv/aeds_out_queue.sv
// ============================================================================
// aeds_out_queue
// Small result queue: takes up to two results a cycle, hands out one.
// ============================================================================
module aeds_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  aeds_pkg::result_t  wr0,
    input  aeds_pkg::result_t  wr1,
    input  logic [1:0]         wr_count,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output aeds_pkg::result_t  head
);
    import aeds_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    result_t         entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [1:0]      n_in;
    logic            pop;

    assign n_in      = wr_en ? wr_count : 2'd0;
    assign pop       = out_valid & ~out_stall;
    assign out_valid = (count_reg != '0);
    assign room      = (count_reg <= CW'(QUEUE_DEPTH - 2));
    assign head      = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + PW'(n_in);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + CW'(n_in) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= wr0;
        end
        if (n_in == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PW'(1)] <= wr1;
        end
    end

endmodule

FILE: sv/arith_expansion_delimiter_scanner.sv
// ============================================================================
// arith_expansion_delimiter_scanner
// Bracket and escape scanner for the body of a shell arithmetic expansion.
// ============================================================================
// Usage: the source feeds the bytes that follow "$((" on the input channel
// (in_valid / in_stall), one request per byte with cmd low, or a request
// with cmd high to mark the end of input. Each request yields zero, one or
// two results on the output channel (out_valid / out_stall): text
// characters with char_valid set, and at most one terminal status. The
// final result of a request carries last. After any terminal status the
// bracket stack and the lookahead are cleared and a new expansion begins.
// The user must write the in_double_quote register on the cfg channel
// (cfg_valid / cfg_ready / cfg_data) only while the block is idle; the
// block itself does not enforce this. cfg_ready is always high.
// Flow: a request accepted into the input register is scanned there, and
// its results go into the result queue, from which they are offered.
// Throughput: one request per cycle. The limit is the output port, which
// hands out one result per cycle, so requests that yield two results run
// at half rate. The four-entry result queue decouples the two sides; when
// it cannot take two more results, the input register holds and in_stall
// rises. Reset empties the queue, the stack and the lookahead.
// ============================================================================
module arith_expansion_delimiter_scanner #(
    parameter int STACK_DEPTH = aeds_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] char_out,
    output logic       char_valid,
    output logic [2:0] status,
    output logic       split_fields,
    output logic       last
);
    import aeds_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Input register.
    logic        in_vld_reg;
    logic        in_vld_next;
    logic        cmd_reg;
    logic [7:0]  byte_reg;
    logic        accept;
    logic        advance;

    // Scanner state.
    logic              dq_reg;
    pend_t             pend_reg;
    pend_t             pend_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    // The stack is a shift line with the top of stack in bit 0.
    logic [STACK_DEPTH-1:0] stack_reg;

    stack_view_t view;
    stack_op_t   op;
    result_t     res0;
    result_t     res1;
    result_t     head;
    logic [1:0]  res_count;
    logic        room;

    assign cfg_ready = 1'b1;

    // The input register advances whenever the queue can take two results.
    assign advance     = in_vld_reg & room;
    assign in_stall    = in_vld_reg & ~room;
    assign accept      = in_valid & ~in_stall;
    assign in_vld_next = accept | (in_vld_reg & ~advance);

    assign view.empty     = (count_reg == '0);
    assign view.full      = (count_reg == CW'(STACK_DEPTH));
    assign view.top_brace = stack_reg[0];

    aeds_step u_step (
        .cmd             (cmd_reg),
        .byte_in         (byte_reg),
        .pend            (pend_reg),
        .view            (view),
        .in_double_quote (dq_reg),
        .res0            (res0),
        .res1            (res1),
        .res_count       (res_count),
        .pend_next       (pend_next),
        .op              (op)
    );

    // A terminal status wins over any push or pop of the same request.
    always_comb
    begin
        if (op.clear)
        begin
            count_next = '0;
        end
        else if (op.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            dq_reg     <= 1'b0;
            pend_reg   <= PEND_NONE;
            count_reg  <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                dq_reg <= cfg_data;
            end
            if (advance)
            begin
                pend_reg  <= pend_next;
                count_reg <= count_next;
            end
        end
    end

    // Payload registers: input byte and the stack contents.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            byte_reg <= byte_in;
        end
        if (advance && !op.clear)
        begin
            if (op.push)
            begin
                stack_reg <= {stack_reg[STACK_DEPTH-2:0], op.push_brace};
            end
            else if (op.pop)
            begin
                stack_reg <= {1'b0, stack_reg[STACK_DEPTH-1:1]};
            end
        end
    end

    aeds_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (advance),
        .wr0       (res0),
        .wr1       (res1),
        .wr_count  (res_count),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign char_out     = head.char_out;
    assign char_valid   = head.char_valid;
    assign status       = head.status;
    assign split_fields = head.split_fields;
    assign last         = head.last;

endmodule
